// ===== design/vdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vdrs_pkg
// Shared types and constants of the voltmeter display and relay scanner.
// ----------------------------------------------------------------------------
package vdrs_pkg;

  // Field widths
  localparam int CODE_W    = 10;
  localparam int SEG_W     = 8;
  localparam int EN_W      = 4;
  localparam int RELAY_W   = 10;
  localparam int MV_W      = 12;
  localparam int COUNT_W   = 4;
  localparam int PERIOD_W  = 16;

  // Millivolt scaling: floor(code * 3300 / 1023) is taken as
  // (code * MV_RECIP) >> MV_SHIFT, where MV_RECIP = 3300 * ceil(2^32 / 1023).
  // The rounding error stays below one part in 1023 over the code range.
  localparam int                MV_SHIFT = 32;
  localparam logic [33:0]       MV_RECIP = 34'd13854736500;
  localparam int                PROD_W   = CODE_W + 34;

  // Scan slots
  localparam logic [2:0] LAST_DIGIT_SLOT = 3'd4;
  localparam logic [1:0] POS_HUNDREDS    = 2'd1;
  localparam logic [7:0] SEG_DP          = 8'h80;

  // Configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_RELAY_COUNT   = 2'd0;
  localparam logic [1:0] REG_SWITCH_PERIOD = 2'd1;
  localparam logic [1:0] REG_DEAD_START    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [COUNT_W-1:0]  RELAY_COUNT_RST   = 4'd10;
  localparam logic [PERIOD_W-1:0] SWITCH_PERIOD_RST = 16'd18000;
  localparam logic [PERIOD_W-1:0] DEAD_START_RST    = 16'd17800;

  typedef struct packed {
    logic [COUNT_W-1:0]  relay_count;
    logic [PERIOD_W-1:0] switch_period;
    logic [PERIOD_W-1:0] dead_start;
  } cfg_t;

  // What the scan sequencer decides for one tick
  typedef struct packed {
    logic               blank;
    logic [1:0]         pos;
    logic [RELAY_W-1:0] drive;
  } meta_t;

  // Seven-segment pattern of one decimal digit, segment a in bit 0
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/vdrs_scan.sv =====
// ----------------------------------------------------------------------------
// vdrs_scan
// Display slot and relay sequencer: steps once per accepted request and
// reports slot, digit position and relay drive for that request.
// ----------------------------------------------------------------------------
module vdrs_scan #(
  parameter int NUM_RELAYS = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  vdrs_pkg::cfg_t cfg,
  output vdrs_pkg::meta_t meta
);

  logic [2:0]                       scan_slot_r, scan_slot_nxt, slot_inc;
  logic [vdrs_pkg::PERIOD_W-1:0]    tick_count_r, tick_count_nxt, tick_inc;
  logic [vdrs_pkg::COUNT_W-1:0]     relay_index_r, relay_index_nxt;
  logic                             relay_active_r, relay_active_nxt;
  logic                             dead, switch_now, blank;
  logic [vdrs_pkg::COUNT_W:0]       idx_inc;

  // Advance the display slot; the slot after the last digit is blank
  always_comb begin
    slot_inc      = scan_slot_r + 3'd1;
    blank         = (slot_inc > vdrs_pkg::LAST_DIGIT_SLOT);
    scan_slot_nxt = blank ? 3'd0 : slot_inc;
  end

  // Tick counter, dead window and relay switch
  always_comb begin
    tick_inc   = tick_count_r + 16'd1;
    dead       = (tick_inc >= cfg.dead_start);
    switch_now = (tick_inc >= cfg.switch_period);

    tick_count_nxt   = switch_now ? '0 : tick_inc;
    relay_active_nxt = switch_now ? 1'b1 : (dead ? 1'b0 : relay_active_r);
    idx_inc          = {1'b0, relay_index_r} + (switch_now ? 5'd1 : 5'd0);

    // Wrap back to relay 1 past the jumper count or the fitted relays
    if (idx_inc > {1'b0, cfg.relay_count} || idx_inc > 5'(NUM_RELAYS)) begin
      relay_index_nxt = 4'd1;
    end else begin
      relay_index_nxt = idx_inc[vdrs_pkg::COUNT_W-1:0];
    end
  end

  // Report the decision for this request
  always_comb begin
    meta.blank = blank;
    meta.pos   = 2'(slot_inc - 3'd1);
    for (int i = 0; i < vdrs_pkg::RELAY_W; i++) begin
      meta.drive[i] = relay_active_nxt && (relay_index_nxt == 4'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_slot_r    <= '0;
      tick_count_r   <= '0;
      relay_index_r  <= '0;
      relay_active_r <= 1'b0;
    end else if (step) begin
      scan_slot_r    <= scan_slot_nxt;
      tick_count_r   <= tick_count_nxt;
      relay_index_r  <= relay_index_nxt;
      relay_active_r <= relay_active_nxt;
    end
  end

endmodule

// ===== design/voltmeter_display_relay_scanner.sv =====
// ----------------------------------------------------------------------------
// voltmeter_display_relay_scanner
// Converts each converter code to millivolts, shows one decimal digit per
// tick on a five-slot multiplexed display and scans a one-hot relay bank.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | in_tdata: adc_code
//  out_    | master    | out_tvalid / out_tready| out_tdata: segments, enables, relays
//  cfg_    | APB slave | psel/penable, pready=1 | relay_count, switch_period, dead_start
//
//  One request per cycle is taken while a stalled output does not back up
//  the pipeline; each gives one result. The path is a five-register pipeline:
//  input, multiply, thousands, hundreds, output register. Stages move on
//  whenever the next one is free, so bubbles are squeezed out under a stalled output.
//  Reset (synchronous, rst_n low) empties the pipeline and clears the scan,
//  relay and segment latch state; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module voltmeter_display_relay_scanner #(
  parameter int NUM_RELAYS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [9:0] adc_code, [15:10] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [7:0] segments, [11:8] digit_enables, [21:12] relay_drive,
  // [23:22] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  vdrs_pkg::cfg_t  cfg_r;
  vdrs_pkg::meta_t in_meta;
  logic            in_acc;
  logic            cfg_we;
  logic [1:0]      cfg_idx;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relay_count   <= vdrs_pkg::RELAY_COUNT_RST;
      cfg_r.switch_period <= vdrs_pkg::SWITCH_PERIOD_RST;
      cfg_r.dead_start    <= vdrs_pkg::DEAD_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vdrs_pkg::REG_RELAY_COUNT:   cfg_r.relay_count   <= cfg_pwdata[3:0];
        vdrs_pkg::REG_SWITCH_PERIOD: cfg_r.switch_period <= cfg_pwdata[15:0];
        vdrs_pkg::REG_DEAD_START:    cfg_r.dead_start    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vdrs_pkg::REG_RELAY_COUNT:   cfg_prdata = {28'd0, cfg_r.relay_count};
      vdrs_pkg::REG_SWITCH_PERIOD: cfg_prdata = {16'd0, cfg_r.switch_period};
      vdrs_pkg::REG_DEAD_START:    cfg_prdata = {16'd0, cfg_r.dead_start};
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- scan and relay sequencer ----------------
  vdrs_scan #(
    .NUM_RELAYS (NUM_RELAYS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .cfg   (cfg_r),
    .meta  (in_meta)
  );

  // ---------------- pipeline registers ----------------
  logic                          s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic                          out_valid_r;
  logic                          s2_rdy, s3_rdy, s4_rdy, out_rdy;
  vdrs_pkg::meta_t               s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r;
  logic [vdrs_pkg::CODE_W-1:0]   s1_code_r;
  logic [vdrs_pkg::MV_W-1:0]     s2_mv_r;
  logic [1:0]                    s3_thou_r, s4_thou_r;
  logic [9:0]                    s3_rem_r;
  logic [3:0]                    s4_hund_r;
  logic [6:0]                    s4_rem_r;
  logic [vdrs_pkg::SEG_W-1:0]    out_seg_r;
  logic [vdrs_pkg::EN_W-1:0]     out_en_r;
  logic [vdrs_pkg::RELAY_W-1:0]  out_drive_r;

  // A stage takes new data when empty or when its content moves on
  assign out_rdy   = !out_valid_r || out_tready;
  assign s4_rdy    = !s4_valid_r || out_rdy;
  assign s3_rdy    = !s3_valid_r || s4_rdy;
  assign s2_rdy    = !s2_valid_r || s3_rdy;
  assign in_tready = !s1_valid_r || s2_rdy;
  assign in_acc    = in_tvalid && in_tready;

  // Scale to millivolts
  logic [vdrs_pkg::PROD_W-1:0] prod;
  assign prod = {34'd0, s1_code_r} * {10'd0, vdrs_pkg::MV_RECIP};

  // Split off the thousands digit
  logic [1:0]  thou;
  logic [11:0] thou_sub;
  always_comb begin
    thou     = '0;
    thou_sub = '0;
    for (int k = 1; k <= 3; k++) begin
      if (s2_mv_r >= 12'(k * 1000)) begin
        thou     = 2'(k);
        thou_sub = 12'(k * 1000);
      end
    end
  end

  // Split off the hundreds digit
  logic [3:0] hund;
  logic [9:0] hund_sub;
  always_comb begin
    hund     = '0;
    hund_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (s3_rem_r >= 10'(k * 100)) begin
        hund     = 4'(k);
        hund_sub = 10'(k * 100);
      end
    end
  end

  // Tens and units, then pick the digit of this slot
  logic [3:0]                 tens, units, digit;
  logic [6:0]                 tens_sub;
  logic [vdrs_pkg::SEG_W-1:0] pattern;
  always_comb begin
    tens     = '0;
    tens_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (s4_rem_r >= 7'(k * 10)) begin
        tens     = 4'(k);
        tens_sub = 7'(k * 10);
      end
    end
    units = 4'(s4_rem_r - tens_sub);

    case (s4_meta_r.pos)
      2'd0:    digit = {2'b00, s4_thou_r};
      2'd1:    digit = s4_hund_r;
      2'd2:    digit = tens;
      default: digit = units;
    endcase

    pattern = vdrs_pkg::seg_of(digit);
    if (s4_meta_r.pos == vdrs_pkg::POS_HUNDREDS) begin
      pattern = pattern | vdrs_pkg::SEG_DP;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r  <= in_tvalid;
      if (s2_rdy)    s2_valid_r  <= s1_valid_r;
      if (s3_rdy)    s3_valid_r  <= s2_valid_r;
      if (s4_rdy)    s4_valid_r  <= s3_valid_r;
      if (out_rdy)   out_valid_r <= s4_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= in_tdata[vdrs_pkg::CODE_W-1:0];
      s1_meta_r <= in_meta;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_mv_r   <= prod[vdrs_pkg::PROD_W-1:vdrs_pkg::MV_SHIFT];
      s2_meta_r <= s1_meta_r;
    end
    if (s3_rdy && s2_valid_r) begin
      s3_thou_r <= thou;
      s3_rem_r  <= 10'(s2_mv_r - thou_sub);
      s3_meta_r <= s2_meta_r;
    end
    if (s4_rdy && s3_valid_r) begin
      s4_thou_r <= s3_thou_r;
      s4_hund_r <= hund;
      s4_rem_r  <= 7'(s3_rem_r - hund_sub);
      s4_meta_r <= s3_meta_r;
    end
  end

  // Output register; the segment field doubles as the display latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_seg_r <= '0;
    end else if (out_rdy && s4_valid_r && !s4_meta_r.blank) begin
      out_seg_r <= pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s4_valid_r) begin
      out_en_r    <= s4_meta_r.blank ? 4'hF : ~(4'd1 << s4_meta_r.pos);
      out_drive_r <= s4_meta_r.drive;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_drive_r, out_en_r, out_seg_r};

endmodule

// ===== design/vdrs_checker.sv =====
// ----------------------------------------------------------------------------
// vdrs_checker
// Port-level checks of the voltmeter display and relay scanner.
// ----------------------------------------------------------------------------
module vdrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Drive at most one relay
  a_relay_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[21:12]))
    else $error("more than one relay driven");

  // Enable at most one digit
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[11:8]) >= 3)
    else $error("more than one digit enabled");

  // Show the decimal point only with the hundreds digit
  a_dp_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[11:8] == 4'b1101)
    else $error("decimal point on wrong digit");

  // Drop results on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind voltmeter_display_relay_scanner vdrs_checker u_vdrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_voltmeter_display_relay_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_voltmeter_display_relay_scanner
// Streams converter codes into the voltmeter display and relay scanner and
// checks every display and relay frame against a cycle-free predictor of
// the scan, the millivolt digits and the relay stepping. Configuration is
// changed only while the block is empty and is read back after each write.
// ----------------------------------------------------------------------------
module tb_voltmeter_display_relay_scanner;

  localparam int NUM_RELAYS  = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int FLUSH_WAIT  = 8;
  localparam int PRINT_CAP   = 40;

  // Seven-segment glyphs, segment a in bit 0
  localparam logic [vdrs_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [vdrs_pkg::RELAY_W-1:0] relays;
    logic [vdrs_pkg::EN_W-1:0]    enables;
    logic [vdrs_pkg::SEG_W-1:0]   segments;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Mirror of the configuration registers
  logic [vdrs_pkg::COUNT_W-1:0]  jumper_count = vdrs_pkg::RELAY_COUNT_RST;
  logic [vdrs_pkg::PERIOD_W-1:0] switch_ticks = vdrs_pkg::SWITCH_PERIOD_RST;
  logic [vdrs_pkg::PERIOD_W-1:0] dead_from    = vdrs_pkg::DEAD_START_RST;

  // Predicted display and relay state
  logic [2:0]                    scan_pos    = '0;
  logic [vdrs_pkg::PERIOD_W-1:0] tick_count  = '0;
  int unsigned                   relay_sel   = 0;
  logic                          relays_live = 1'b0;
  logic [vdrs_pkg::SEG_W-1:0]    glyph_latch = '0;

  frame_t pending_frames [$];
  int     error_count   = 0;
  int     codes_sent    = 0;
  int     frames_seen   = 0;
  int     settings_used = 0;
  int     quiet_cycles  = 0;
  int     hold_left     = 0;
  int     stall_left    = 0;
  bit     in_idle_on    = 1'b0;
  bit     out_idle_on   = 1'b0;

  voltmeter_display_relay_scanner #(
    .NUM_RELAYS(NUM_RELAYS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH %s: got 0x%0h, want 0x%0h (frame %0d)", what, got, want,
               frames_seen);
    end
  endtask

  // Advance the predicted scan and relay state by one tick
  function automatic frame_t advance_display(input logic [vdrs_pkg::CODE_W-1:0] code);
    int unsigned millivolts;
    int unsigned digit [4];
    int unsigned next_sel;
    int unsigned pos;
    frame_t      f;
    millivolts = (32'(code) * 32'd3300) / 32'd1023;
    digit[0] = (millivolts / 1000) % 10;
    digit[1] = (millivolts % 1000) / 100;
    digit[2] = (millivolts % 100) / 10;
    digit[3] = millivolts % 10;
    f.enables = '1;
    f.relays  = '0;
    scan_pos   = scan_pos + 3'd1;
    tick_count = tick_count + 16'd1;
    // Dead window, then the switch itself
    if (tick_count >= dead_from) relays_live = 1'b0;
    next_sel = relay_sel;
    if (tick_count >= switch_ticks) begin
      tick_count  = '0;
      next_sel    = relay_sel + 1;
      relays_live = 1'b1;
    end
    // Digit slots latch a glyph; the blank slot holds it and wraps the scan
    if (scan_pos >= 3'd1 && scan_pos <= vdrs_pkg::LAST_DIGIT_SLOT) begin
      pos = scan_pos - 3'd1;
      glyph_latch = DIGIT_GLYPH[digit[pos]];
      if (pos == vdrs_pkg::POS_HUNDREDS) glyph_latch = glyph_latch | vdrs_pkg::SEG_DP;
      f.enables[pos] = 1'b0;
    end else begin
      scan_pos = '0;
    end
    relay_sel = (next_sel > jumper_count || next_sel > NUM_RELAYS) ? 1 : next_sel;
    if (relays_live && relay_sel >= 1 && relay_sel <= vdrs_pkg::RELAY_W) begin
      f.relays[relay_sel-1] = 1'b1;
    end
    f.segments = glyph_latch;
    return f;
  endfunction

  // Offer one converter code and log its frame once the request is taken
  task automatic send_code(input logic [vdrs_pkg::CODE_W-1:0] code);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(16-vdrs_pkg::CODE_W){1'b0}}, code};
    do @(posedge clk); while (!in_tready);
    pending_frames.push_back(advance_display(code));
    codes_sent++;
  endtask

  task automatic send_random_codes(input int count);
    repeat (count) send_code(vdrs_pkg::CODE_W'($urandom_range(0, 1023)));
  endtask

  // Drop valid and hold until every frame is back and the pipeline is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
  endtask

  // Setup and access phase, then the bus goes idle
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    apb_transfer(1'b0, idx, '0, got);
    if (got !== want) report_mismatch($sformatf("register %0d readback", idx), got, want);
  endtask

  // Write all three registers, keep the mirror in step and read them back
  task automatic set_relay_config(input logic [vdrs_pkg::COUNT_W-1:0] count,
                                  input logic [vdrs_pkg::PERIOD_W-1:0] period,
                                  input logic [vdrs_pkg::PERIOD_W-1:0] dead);
    logic [31:0] unused;
    apb_transfer(1'b1, vdrs_pkg::REG_RELAY_COUNT, 32'(count), unused);
    apb_transfer(1'b1, vdrs_pkg::REG_SWITCH_PERIOD, 32'(period), unused);
    apb_transfer(1'b1, vdrs_pkg::REG_DEAD_START, 32'(dead), unused);
    jumper_count = count;
    switch_ticks = period;
    dead_from    = dead;
    settings_used++;
    check_register(vdrs_pkg::REG_RELAY_COUNT, 32'(count));
    check_register(vdrs_pkg::REG_SWITCH_PERIOD, 32'(period));
    check_register(vdrs_pkg::REG_DEAD_START, 32'(dead));
  endtask

  // Digit boundaries and code extremes under the reset configuration
  task automatic test_default_readout();
    logic [vdrs_pkg::CODE_W-1:0] codes [$];
    codes = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd310, 10'd309, 10'd31, 10'd3,
              10'd341, 10'd512, 10'd620, 10'd682, 10'd930, 10'h155, 10'h2AA,
              10'd992, 10'd279, 10'd1023, 10'd0, 10'd311};
    check_register(vdrs_pkg::REG_RELAY_COUNT, 32'(vdrs_pkg::RELAY_COUNT_RST));
    check_register(vdrs_pkg::REG_SWITCH_PERIOD, 32'(vdrs_pkg::SWITCH_PERIOD_RST));
    check_register(vdrs_pkg::REG_DEAD_START, 32'(vdrs_pkg::DEAD_START_RST));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    foreach (codes[i]) send_code(codes[i]);
    wait_drained();
  endtask

  // Relay count zero, wrap past ten, zero period, dead window placements
  task automatic test_relay_corners();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    set_relay_config(4'd0, 16'd3, 16'd1);
    send_random_codes(20);
    wait_drained();
    set_relay_config(4'd15, 16'd2, 16'hFFFF);
    send_random_codes(30);
    wait_drained();
    set_relay_config(4'd4, 16'd0, 16'd0);
    send_random_codes(20);
    wait_drained();
    set_relay_config(4'd10, 16'd5, 16'd5);
    send_random_codes(20);
    wait_drained();
    set_relay_config(4'd10, 16'd6, 16'd3);
    send_random_codes(25);
    wait_drained();
    set_relay_config(4'd3, 16'd4, 16'd0);
    send_random_codes(20);
    wait_drained();
    // Shrink the relay count under the current index
    set_relay_config(4'd1, 16'hFFFF, 16'h5555);
    send_random_codes(15);
    wait_drained();
    set_relay_config(4'd2, 16'h5555, 16'hAAAA);
    send_random_codes(15);
    wait_drained();
  endtask

  // Random settings, mostly short periods so that the relays keep stepping
  task automatic test_random_settings();
    int unsigned period;
    int unsigned dead;
    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(0, 7))
        0:       period = 0;
        1:       period = 16'hFFFF;
        2:       period = $urandom_range(0, 1) ? 16'hAAAA : 16'h5555;
        default: period = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       dead = 0;
        1:       dead = 16'hFFFF;
        2:       dead = period + $urandom_range(0, 3);
        default: dead = $urandom_range(0, period % 64 + 2);
      endcase
      set_relay_config(vdrs_pkg::COUNT_W'($urandom_range(0, 15)),
                       vdrs_pkg::PERIOD_W'(period), vdrs_pkg::PERIOD_W'(dead));
      in_idle_on  = phase % 4 != 1;
      out_idle_on = phase % 4 != 2;
      send_random_codes($urandom_range(35, 75));
      wait_drained();
    end
  endtask

  // Long output stall with the sender still pushing, then a full pause
  task automatic test_backpressure();
    set_relay_config(4'd7, 16'd9, 16'd6);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    @(negedge clk);
    hold_left = LONG_HOLD;
    @(posedge clk);
    send_random_codes(80);
    wait_drained();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_random_codes(40);
    wait_drained();
  endtask

  // Frame checker and output stall generator
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        frames_seen++;
        if (pending_frames.size() == 0) begin
          report_mismatch("frame with none pending", 32'(out_tdata), '0);
        end else begin
          want = pending_frames.pop_front();
          if (out_tdata[7:0] !== want.segments)
            report_mismatch("segments", 32'(out_tdata[7:0]), 32'(want.segments));
          if (out_tdata[11:8] !== want.enables)
            report_mismatch("digit_enables", 32'(out_tdata[11:8]), 32'(want.enables));
          if (out_tdata[21:12] !== want.relays)
            report_mismatch("relay_drive", 32'(out_tdata[21:12]), 32'(want.relays));
          if (out_tdata[23:22] !== 2'b00)
            report_mismatch("tdata padding", 32'(out_tdata[23:22]), '0);
        end
        stall_left = out_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Abort when no request moves on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("tb_voltmeter_display_relay_scanner: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_readout();
    test_relay_corners();
    test_random_settings();
    test_backpressure();
    wait_drained();
    $display("Streamed %0d converter codes and checked %0d display/relay frames.",
             codes_sent, frames_seen);
    $display("Relay settings applied and read back: %0d; mismatches: %0d.",
             settings_used, error_count);
    if (error_count == 0) begin
      $display("tb_voltmeter_display_relay_scanner: clean");
    end else begin
      $display("tb_voltmeter_display_relay_scanner: errors");
    end
    $finish;
  end

endmodule
